### sv/assert_macros.svh
// Assertion macros used by the allocator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk, off during rst.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/bba_pkg.sv
// Types and constants of the block bitmap allocator.
package bba_pkg;

  localparam int unsigned WORD_W = 8;

  localparam logic [1:0] OP_MARK    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TEST    = 2'd2;
  localparam logic [1:0] OP_FIND    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [9:0] BLOCK_COUNT_RST = 10'd512;

  typedef struct packed {
    logic [1:0] operation;
    logic [8:0] block_index;
  } cmd_t;

  typedef struct packed {
    logic       bit_value;
    logic [8:0] found_block;
    logic [1:0] status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
    logic clr_wr;
    logic row_inc;
    logic fin;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic find;
    logic range_err;
    logic hit;
    logic last_row;
    logic clr_last;
  } sts_t;

endpackage

### sv/bba_dpath.sv
// Allocator datapath: usage map memory, row counter, scan and result logic.
module bba_dpath #(
  parameter int unsigned NUM_BLOCKS = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  bba_pkg::cmd_t command,
  input  logic          cfg_we,
  input  logic [9:0]    cfg_wdata,
  input  bba_pkg::ctl_t ctl,
  output bba_pkg::sts_t sts,
  output logic          done,
  output bba_pkg::rsp_t result
);

  localparam int unsigned ROWS  = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [bba_pkg::WORD_W-1:0] mem [ROWS];
  logic [bba_pkg::WORD_W-1:0] rd_data;
  logic [bba_pkg::WORD_W-1:0] wr_data;
  logic [bba_pkg::WORD_W-1:0] mod_data;
  logic [bba_pkg::WORD_W-1:0] valid;
  logic [bba_pkg::WORD_W-1:0] free;
  logic [ROW_W-1:0]           row;
  logic [ROW_W-1:0]           idx_row;
  logic [ROW_W-1:0]           wr_addr;
  logic [ROW_W-1:0]           rd_addr;
  logic                       wr_en;
  logic [9:0]                 block_count;
  logic [9:0]                 lim;
  logic [16:0]                lim_ext;
  logic [16:0]                idx_ext;
  logic [16:0]                base;
  logic [2:0]                 pos;
  logic [2:0]                 bit_sel;
  bba_pkg::cmd_t              cmd_q;
  bba_pkg::rsp_t              rsp_next;

  // block_count saturated to the map size
  assign lim     = ({7'd0, block_count} > 17'(NUM_BLOCKS)) ? 10'(NUM_BLOCKS) : block_count;
  assign lim_ext = {7'd0, lim};
  assign idx_ext = {8'd0, cmd_q.block_index};
  assign idx_row = idx_ext[ROW_W+2:3];
  assign bit_sel = cmd_q.block_index[2:0];
  assign base    = 17'({row, 3'b000});

  always_comb begin
    for (int j = 0; j < bba_pkg::WORD_W; j++) begin
      valid[j] = (base + 17'(j)) < lim_ext;
    end
  end

  assign free = ~rd_data & valid;

  always_comb begin
    pos = '0;
    for (int j = bba_pkg::WORD_W - 1; j >= 0; j--) begin
      if (free[j]) begin
        pos = 3'(j);
      end
    end
  end

  assign sts.find      = (cmd_q.operation == bba_pkg::OP_FIND);
  assign sts.range_err = ({1'b0, cmd_q.block_index} >= lim);
  assign sts.hit       = |free;
  assign sts.last_row  = (base + 17'(bba_pkg::WORD_W)) >= lim_ext;
  assign sts.clr_last  = (row == ROW_W'(ROWS - 1));

  assign mod_data = (cmd_q.operation == bba_pkg::OP_MARK) ?
                    (rd_data | (8'd1 << bit_sel)) : (rd_data & ~(8'd1 << bit_sel));
  assign wr_en    = ctl.clr_wr || (ctl.commit && (cmd_q.operation == bba_pkg::OP_MARK ||
                                                  cmd_q.operation == bba_pkg::OP_RELEASE));
  assign wr_addr  = ctl.clr_wr ? row : idx_row;
  assign wr_data  = ctl.clr_wr ? '0 : mod_data;
  assign rd_addr  = sts.find ? row : idx_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    rsp_next = '0;
    if (sts.find) begin
      if (sts.hit) begin
        rsp_next.found_block = 9'(base + 17'(pos));
      end else begin
        rsp_next.status = bba_pkg::ST_NONE_FREE;
      end
    end else if (sts.range_err) begin
      rsp_next.status = bba_pkg::ST_RANGE;
    end else if (cmd_q.operation == bba_pkg::OP_TEST) begin
      rsp_next.bit_value = rd_data[bit_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row         <= '0;
      block_count <= bba_pkg::BLOCK_COUNT_RST;
      done        <= 1'b0;
    end else begin
      if (ctl.load) begin
        row <= '0;
      end else if (ctl.row_inc) begin
        row <= row + ROW_W'(1);
      end
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      done <= ctl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= command;
    end
    if (ctl.fin) begin
      result <= rsp_next;
    end
  end

endmodule

### sv/bba_ctrl.sv
// Allocator controller: map clearing pass, command sequencing, scan loop.
`include "assert_macros.svh"

module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bba_pkg::sts_t sts,
  output bba_pkg::ctl_t ctl,
  output logic          busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ACCESS,
    S_FIND_RD,
    S_FIND_EVAL
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end else begin
          ctl.row_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.find) begin
          ctl.rd     = 1'b1;
          state_next = S_FIND_EVAL;
        end else if (sts.range_err) begin
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.rd     = 1'b1;
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        ctl.commit = 1'b1;
        ctl.fin    = 1'b1;
        state_next = S_IDLE;
      end
      S_FIND_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_FIND_EVAL;
      end
      S_FIND_EVAL: begin
        if (sts.hit || sts.last_row) begin
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.row_inc = 1'b1;
          state_next  = S_FIND_RD;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_NEXT(a_accept_dispatch, start && !busy, state == S_DISPATCH)
  `ASSERT_NEXT(a_fin_idle, ctl.fin, state == S_IDLE)
  `ASSERT_NOW(a_commit_in_range, ctl.commit, !sts.range_err && !sts.find)
  `ASSERT_NOW(a_clear_no_load, state == S_CLEAR, !ctl.load && !ctl.fin)

endmodule

### sv/block_bitmap_allocator_top.sv
// Block bitmap allocator top level: controller plus datapath.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------
//   command  | start / busy     | operation, block_index
//   result   | done strobe      | bit_value, found_block, status
//   config   | cfg_we           | cfg_wdata (block_count)
//
// After reset the map is cleared one byte row per cycle with busy high.
// Mark, release and test read the map row in dispatch, then in the access
// state mark and release write it back and the result is latched; out of range
// finishes in dispatch. One map memory read per access. Find reads one 8-block
// row at a time, alternating read and evaluate states, up to the first row with
// a free block or the last row; a zero count still scans one row.
// A beat is accepted whenever busy is low, including the cycle of done.
// The receiver cannot stall; done is high for exactly one cycle per beat.
module block_bitmap_allocator_top #(
  parameter int unsigned NUM_BLOCKS = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bba_pkg::cmd_t command,
  output logic          done,
  output bba_pkg::rsp_t result,
  input  logic          cfg_we,
  input  logic [9:0]    cfg_wdata
);

  bba_pkg::ctl_t ctl;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  bba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule
